>>> hdl/lrs_pkg.sv
// Shared widths, item layouts and result type for the linear recurrence scan.
package lrs_pkg;

   localparam int CH_W    = 8;
   localparam int COEF_W  = 18;
   localparam int TERM_W  = 32;
   localparam int VAL_W   = 32;
   localparam int Q_SHIFT = 16;

   // Exact product of a Q2.16 coefficient and a Q16.16 state.
   localparam int PROD_W = COEF_W + VAL_W;
   // Product after dropping the fraction bits below Q16.16.
   localparam int RND_W  = PROD_W - Q_SHIFT;
   // One guard bit for the addition of the input term.
   localparam int SUM_W  = RND_W + 1;

   typedef struct packed {
      logic [CH_W-1:0]          channel;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [TERM_W-1:0] term_b;
      logic                     seq_start;
   } elem_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    saturated;
   } upd_type;

endpackage

>>> hdl/linear_recurrence_scan.sv
// Top level of the per-channel first-order linear recurrence scan.
//
// Each item names a channel and carries a Q2.16 decay coefficient and a Q16.16
// input term; the block replaces that channel's running state with
// a*state + b (product rounded half up to Q16.16, sum clamped to 32 bits) and
// returns the new state with the channel index and a flag that is set when
// the clamp acted. An item with seq_start set takes its prior state as zero.
// Channel indexes are reduced modulo CHANNELS to pick the state entry, while
// the echoed index is the one that came in. The block takes one item per
// clock cycle while the result side is ready, and each result passes from
// the input stage through the result register; that rate is held even for
// the same channel in consecutive cycles, because the freshly written state
// is forwarded around the state memory into the single registered
// multiply-add stage. After reset the state memory is cleared one entry per
// cycle, so req_tready stays low until every entry is cleared.
module linear_recurrence_scan
   import lrs_pkg::*;
#(
   parameter int CHANNELS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata, from bit 0 up: channel[7:0], coef_a[17:0], term_b[31:0],
   // then six zero bits.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // req_tuser: seq_start.
   input  logic        req_tuser,
   // rsp_tdata, from bit 0 up: result_value[31:0], result_channel[7:0].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // rsp_tuser: saturated.
   output logic        rsp_tuser
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);
   localparam int NUM_CODES = 1 << CH_W;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // Incoming item, unpacked from the stream.
   elem_type   req_elem;
   logic [IDX_W-1:0] req_idx;
   logic       req_fire;

   // Channel index to state entry, worked out at elaboration.
   logic [IDX_W-1:0] idx_tab [NUM_CODES];

   // Input stage: the item waiting for its update, with its state read.
   logic       s1_vld_ff, s1_vld_in;
   elem_type   s1_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic       s1_adv;

   // The state memory and its registered read port.
   logic [VAL_W-1:0] state_mem [CHANNELS];
   logic [VAL_W-1:0] mem_rd_ff;
   logic       wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [VAL_W-1:0] wr_data;

   // Forwarding of the state written in the same cycle as the read.
   logic       byp_ff, byp_in;
   logic [VAL_W-1:0] byp_val_ff;

   // Clearing pass after reset.
   logic       clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   // Update logic.
   logic signed [VAL_W-1:0] prior;
   upd_type    upd;

   // Result register.
   logic       rsp_vld_ff, rsp_vld_in;
   logic [VAL_W-1:0] rsp_val_ff;
   logic [CH_W-1:0]  rsp_ch_ff;
   logic       rsp_sat_ff;

   for (genvar g = 0; g < NUM_CODES; g++) begin : g_idx_tab
      localparam int ENTRY = g % CHANNELS;
      assign idx_tab[g] = IDX_W'(ENTRY);
   end

   assign req_elem.channel   = req_tdata[7:0];
   assign req_elem.coef_a    = req_tdata[25:8];
   assign req_elem.term_b    = req_tdata[57:26];
   assign req_elem.seq_start = req_tuser;
   assign req_idx            = idx_tab[req_elem.channel];

   // The input stage moves on whenever the result register is free or drains.
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_vld_ff || s1_adv);
   assign req_fire   = req_tvalid && req_tready;

   // A new state is written back in the cycle it moves to the result register.
   assign wr_en   = clr_busy_ff || s1_adv;
   assign wr_idx  = clr_busy_ff ? clr_idx_ff : s1_idx_ff;
   assign wr_data = clr_busy_ff ? '0 : upd.value;

   always_comb begin
      s1_vld_in   = s1_vld_ff;
      rsp_vld_in  = rsp_vld_ff;
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      byp_in      = byp_ff;
      if (req_fire) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (clr_busy_ff) begin
         if (clr_idx_ff == IDX_LAST) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end
      // The read at acceptance misses a write to the same entry in that cycle.
      if (req_fire) begin
         byp_in = s1_adv && (s1_idx_ff == req_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
         byp_ff      <= 1'b0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
         byp_ff      <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_idx] <= wr_data;
      end
      if (req_fire) begin
         mem_rd_ff <= state_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff      <= req_elem;
         s1_idx_ff  <= req_idx;
         byp_val_ff <= upd.value;
      end
      if (s1_adv) begin
         rsp_val_ff <= upd.value;
         rsp_ch_ff  <= s1_ff.channel;
         rsp_sat_ff <= upd.saturated;
      end
   end

   always_comb begin
      if (s1_ff.seq_start) begin
         prior = '0;
      end else if (byp_ff) begin
         prior = byp_val_ff;
      end else begin
         prior = mem_rd_ff;
      end
   end

   lrs_update u_update (
      .coef_a (s1_ff.coef_a),
      .term_b (s1_ff.term_b),
      .prior  (prior),
      .upd    (upd)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_ch_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_sat_ff;

   // No item may enter while the state memory is still being cleared.
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("item accepted during the clearing pass");

   // A clamped result is one of the two range limits.
   a_sat_is_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_val_ff == VAL_MAX || rsp_val_ff == VAL_MIN))
      else $error("saturated result is not a range limit");

   // A sequence start returns the input term itself, which never clamps.
   a_start_no_sat: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_ff.seq_start) |=> (rsp_tvalid && !rsp_tuser))
      else $error("sequence start produced a saturated result");

   // Every update that leaves the input stage shows up as a result.
   a_update_reaches_output: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_tvalid)
      else $error("update lost between input stage and result register");

endmodule

>>> hdl/lrs_update.sv
// Fixed-point update a*state + b with round-half-up and saturation.
module lrs_update
   import lrs_pkg::*;
(
   input  logic signed [COEF_W-1:0] coef_a,
   input  logic signed [TERM_W-1:0] term_b,
   input  logic signed [VAL_W-1:0]  prior,
   output upd_type                  upd
);

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (Q_SHIFT - 1);

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [RND_W-1:0]  scaled;
   logic signed [SUM_W-1:0]  sum;
   logic                     in_range;

   always_comb begin
      prod     = PROD_W'(coef_a) * PROD_W'(prior);
      prod_rnd = prod + HALF_LSB;
      // Arithmetic drop of the low bits is the floor of the division.
      scaled   = $signed(prod_rnd[PROD_W-1:Q_SHIFT]);
      sum      = SUM_W'(scaled) + SUM_W'(term_b);
      // The sum fits when every bit above the result's sign bit matches it.
      in_range = (sum[SUM_W-1:VAL_W-1] == '0) || (sum[SUM_W-1:VAL_W-1] == '1);
      if (in_range) begin
         upd.value     = sum[VAL_W-1:0];
         upd.saturated = 1'b0;
      end else begin
         upd.value     = sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
         upd.saturated = 1'b1;
      end
   end

endmodule
